FILE: rtl/core/srfc_pkg.sv
// ----------------------------------------------------------------------------
// srfc_pkg: shared definitions for the sync frame re-framer
// Byte codes of the sync pair and the output header, the command that the
// front end hands to the back end, and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package srfc_pkg;

    // Sync pair searched for in the received stream.
    localparam logic [7:0] SYNC_FIRST  = 8'hBB;
    localparam logic [7:0] SYNC_SECOND = 8'h33;

    // Header of a re-framed output frame.
    localparam logic [7:0] HEAD_FIRST  = 8'hAA;
    localparam logic [7:0] HEAD_SECOND = 8'h55;
    localparam logic [7:0] HEAD_TAG    = 8'h07;

    // Default depth of the command queue between front and back end.
    localparam int QUEUE_DEPTH_DEF = 4;

    // What the back end has to emit for one command.
    typedef enum logic [1:0] {
        CMD_HEADER  = 2'd0,   // four header bytes, data holds the length field
        CMD_PAYLOAD = 2'd1,   // one payload byte
        CMD_LAST    = 2'd2    // last payload byte followed by the checksum
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
        logic [7:0] sum;
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/sync_frame_reframer_checksum_unit.sv
// ----------------------------------------------------------------------------
// sync_frame_reframer_checksum_unit: sync frame re-framer with sum checksum
// Top level joining parser, command queue and output sequencer.
// ----------------------------------------------------------------------------
// The block hunts the received byte stream for the pair 0xBB 0x33, reads a
// length byte L and L payload bytes, and streams out 0xAA 0x55 (L+1) 0x07,
// the payload and a mod-256 sum of all bytes emitted before it; L = 0 emits
// nothing. Each input byte that causes output is queued as a command; the
// output side emits one item per cycle unless m_axis_tready stalls it or
// the queue is empty. A length byte yields four output items, a payload
// byte one, the last payload byte two. Up to QUEUE_DEPTH commands wait in
// the queue; input is taken back to back while it has room. m_axis_tlast
// marks the last output item of one input item; m_axis_tuser a checksum.
`default_nettype none

module sync_frame_reframer_checksum_unit #(
    parameter int QUEUE_DEPTH = srfc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,    // [7:0] rx_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,    // [7:0] tx_byte
    output logic            m_axis_tlast,    // last_of_run
    output logic            m_axis_tuser     // [0] frame_end
);

    import srfc_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic front_push;
    logic queue_full;
    logic queue_empty;
    logic back_pop;
    logic in_accept;

    assign s_axis_tready = !queue_full;
    assign in_accept     = s_axis_tvalid && !queue_full;

    // Parser.
    srfc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_axis_tdata),
        .cmd       (front_cmd),
        .cmd_push  (front_push)
    );

    // Command queue.
    srfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (front_push),
        .push_cmd (front_cmd),
        .full     (queue_full),
        .pop      (back_pop),
        .head_cmd (head_cmd),
        .empty    (queue_empty)
    );

    // Output sequencer.
    srfc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_cmd      (head_cmd),
        .head_valid    (!queue_empty),
        .pop           (back_pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_byte      (m_axis_tdata),
        .out_last      (m_axis_tlast),
        .out_frame_end (m_axis_tuser)
    );

endmodule

`default_nettype wire

FILE: rtl/core/srfc_front.sv
// ----------------------------------------------------------------------------
// srfc_front: sync hunt and frame parser
// Accepts received bytes, tracks the hunt phase, the remaining payload count
// and the running checksum, and issues one command per byte that causes output.
// ----------------------------------------------------------------------------
`default_nettype none

module srfc_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_accept,
    input  wire logic [7:0]    in_byte,
    output srfc_pkg::cmd_t     cmd,
    output logic               cmd_push
);

    import srfc_pkg::*;

    typedef enum logic [1:0] {
        HUNT_FIRST  = 2'd0,
        HUNT_SECOND = 2'd1,
        GET_LENGTH  = 2'd2,
        PAYLOAD     = 2'd3
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] remaining_reg, remaining_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] len_field;
    logic [7:0] pay_sum;

    assign len_field = in_byte + 8'd1;
    assign pay_sum   = sum_reg + in_byte;

    // Next-state and command decode for the accepted item.
    always_comb begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        sum_next       = sum_reg;
        cmd_push       = 1'b0;
        cmd.kind       = CMD_PAYLOAD;
        cmd.data       = in_byte;
        cmd.sum        = pay_sum;
        if (in_accept) begin
            unique case (phase_reg)
                HUNT_FIRST: begin
                    phase_next = (in_byte == SYNC_FIRST) ? HUNT_SECOND : HUNT_FIRST;
                end
                HUNT_SECOND: begin
                    phase_next = (in_byte == SYNC_SECOND) ? GET_LENGTH : HUNT_FIRST;
                end
                GET_LENGTH: begin
                    if (in_byte == 8'd0) begin
                        phase_next     = HUNT_FIRST;
                        remaining_next = 8'd0;
                    end else begin
                        phase_next     = PAYLOAD;
                        remaining_next = in_byte;
                        sum_next       = HEAD_FIRST + HEAD_SECOND + len_field + HEAD_TAG;
                        cmd_push       = 1'b1;
                        cmd.kind       = CMD_HEADER;
                        cmd.data       = len_field;
                    end
                end
                PAYLOAD: begin
                    if (remaining_reg == 8'd0) begin
                        // Cannot arise in normal operation; drop the item.
                        phase_next = HUNT_FIRST;
                    end else if (remaining_reg == 8'd1) begin
                        phase_next     = HUNT_FIRST;
                        remaining_next = 8'd0;
                        sum_next       = 8'd0;
                        cmd_push       = 1'b1;
                        cmd.kind       = CMD_LAST;
                    end else begin
                        remaining_next = remaining_reg - 8'd1;
                        sum_next       = pay_sum;
                        cmd_push       = 1'b1;
                        cmd.kind       = CMD_PAYLOAD;
                    end
                end
            endcase
        end
    end

    // Parser state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= HUNT_FIRST;
            remaining_reg <= 8'd0;
            sum_reg       <= 8'd0;
        end else begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            sum_reg       <= sum_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/srfc_queue.sv
// ----------------------------------------------------------------------------
// srfc_queue: command queue
// A short first-in first-out store of commands that decouples the parser
// from the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module srfc_queue #(
    parameter int DEPTH = srfc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  srfc_pkg::cmd_t      push_cmd,
    output logic                full,
    input  wire logic           pop,
    output srfc_pkg::cmd_t      head_cmd,
    output logic                empty
);

    import srfc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = store_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/srfc_back.sv
// ----------------------------------------------------------------------------
// srfc_back: output sequencer
// Expands each queued command into its output items, one per cycle while
// out_ready does not stall it, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module srfc_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  srfc_pkg::cmd_t     head_cmd,
    input  wire logic          head_valid,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic               out_last,
    output logic               out_frame_end
);

    import srfc_pkg::*;

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       fend_reg;
    logic       load;
    logic       final_sub;
    logic [7:0] sub_byte;
    logic       sub_last;
    logic       sub_fend;

    assign load          = head_valid && (!valid_reg || out_ready);
    assign pop           = load && final_sub;
    assign out_valid     = valid_reg;
    assign out_byte      = byte_reg;
    assign out_last      = last_reg;
    assign out_frame_end = fend_reg;

    // Select the item that the current step of the command emits.
    always_comb begin
        sub_byte  = head_cmd.data;
        sub_last  = 1'b1;
        sub_fend  = 1'b0;
        final_sub = 1'b1;
        unique case (head_cmd.kind)
            CMD_HEADER: begin
                unique case (idx_reg)
                    2'd0: begin
                        sub_byte  = HEAD_FIRST;
                        sub_last  = 1'b0;
                        final_sub = 1'b0;
                    end
                    2'd1: begin
                        sub_byte  = HEAD_SECOND;
                        sub_last  = 1'b0;
                        final_sub = 1'b0;
                    end
                    2'd2: begin
                        sub_byte  = head_cmd.data;
                        sub_last  = 1'b0;
                        final_sub = 1'b0;
                    end
                    2'd3: begin
                        sub_byte = HEAD_TAG;
                    end
                endcase
            end
            CMD_LAST: begin
                if (idx_reg == 2'd0) begin
                    sub_byte  = head_cmd.data;
                    sub_last  = 1'b0;
                    final_sub = 1'b0;
                end else begin
                    sub_byte = head_cmd.sum;
                    sub_fend = 1'b1;
                end
            end
            default: begin
                sub_byte = head_cmd.data;
            end
        endcase
    end

    // Step counter and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg   <= final_sub ? 2'd0 : idx_reg + 2'd1;
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= sub_byte;
            last_reg <= sub_last;
            fend_reg <= sub_fend;
        end
    end

endmodule

`default_nettype wire
